// ----- rtl/aps_pkg.sv -----
// Shared types and constants for the aging priority scheduler.
package aps_pkg;

	// Default number of task slots
	localparam int MaxTasksDef = 16;

	// Register reset values
	localparam logic [7:0] QUANTUM_RST = 8'd20;
	localparam logic [3:0] AGING_RST   = 4'd1;

	// Static priority limits
	localparam logic signed [5:0] PRIO_MAX = 6'sd19;
	localparam logic signed [5:0] PRIO_MIN = -6'sd20;

	// Saturation floor of the dynamic priority
	localparam logic signed [8:0] DYN_FLOOR = -9'sd128;

	// Register indexes on the APB port
	localparam logic REG_QUANTUM = 1'b0;
	localparam logic REG_AGING   = 1'b1;

	typedef enum logic [1:0] {
		ACT_READY   = 2'd0,
		ACT_PICK    = 2'd1,
		ACT_TICK    = 2'd2,
		ACT_SETPRIO = 2'd3
	} action_t;

	// Decoded command held in the front queue
	typedef struct packed {
		action_t            op;
		logic [3:0]         slot;
		logic               slot_ok;
		logic               new_task;
		logic signed [5:0]  prio;
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} back_state_t;

endpackage

// ----- rtl/aps_if.sv -----
// Item channels of the scheduler: request and response interfaces.
interface aps_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [3:0]        task_slot;
	logic              new_task;
	logic signed [5:0] priority_req;

	modport source(output valid, action, task_slot, new_task, priority_req, input ready);
	modport sink(input valid, action, task_slot, new_task, priority_req, output ready);
endinterface

interface aps_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] chosen_slot;
	logic       chosen_valid;
	logic       preempt;
	logic       rejected;
	logic [4:0] ready_count;

	modport source(output valid, chosen_slot, chosen_valid, preempt, rejected, ready_count,
		input ready);
	modport sink(input valid, chosen_slot, chosen_valid, preempt, rejected, ready_count,
		output ready);
endinterface

// ----- rtl/aps_front.sv -----
// Front end: accepts items, decodes them and buffers them in a two-entry queue.
module aps_front #(
	parameter int MAX_TASKS = aps_pkg::MaxTasksDef
) (
	input  logic           clk,
	input  logic           arst_n,
	aps_req_if.sink        req,
	output aps_pkg::cmd_t  q_head,
	output logic           q_valid,
	input  logic           q_pop
);

	aps_pkg::cmd_t     fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	aps_pkg::cmd_t     dec;
	logic              push;

	// Decode: range check of the slot, saturation of the requested priority
	always_comb begin
		dec.op       = aps_pkg::action_t'(req.action);
		dec.slot     = req.task_slot;
		dec.slot_ok  = (32'(req.task_slot) < MAX_TASKS);
		dec.new_task = req.new_task;
		if (req.priority_req > aps_pkg::PRIO_MAX) begin
			dec.prio = aps_pkg::PRIO_MAX;
		end else if (req.priority_req < aps_pkg::PRIO_MIN) begin
			dec.prio = aps_pkg::PRIO_MIN;
		end else begin
			dec.prio = req.priority_req;
		end
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_head    = fifo_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/aps_back.sv -----
// Back end: task tables, ready order, pick scan, tick budget and result register.
module aps_back #(
	parameter int MAX_TASKS = aps_pkg::MaxTasksDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  aps_pkg::cmd_t  q_head,
	input  logic           q_valid,
	output logic           q_pop,
	input  logic [7:0]     quantum,
	input  logic [3:0]     aging_step,
	aps_rsp_if.source      rsp
);

	localparam int SLOT_W = $clog2(MAX_TASKS);
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);

	logic signed [5:0]   static_q [MAX_TASKS];
	logic signed [7:0]   dyn_q    [MAX_TASKS];
	logic [SLOT_W-1:0]   order_q  [MAX_TASKS];
	logic [MAX_TASKS-1:0] ready_q;
	logic [CNT_W-1:0]    total_q;
	logic [SLOT_W-1:0]   run_slot_q;
	logic                run_valid_q;
	logic [7:0]          budget_q;

	aps_pkg::back_state_t state_q, state_d;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    best_idx_q;
	logic [SLOT_W-1:0]   best_slot_q;
	logic signed [7:0]   best_prio_q;

	logic                out_valid_q;
	logic [3:0]          out_slot_q;
	logic                out_cvalid_q;
	logic                out_preempt_q;
	logic                out_reject_q;

	logic                out_free;
	logic [SLOT_W-1:0]   cmd_slot;
	logic [SLOT_W-1:0]   scan_slot;
	logic                scan_done;
	logic                commit;
	logic                do_ready;
	logic                do_set;
	logic                rej;

	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd_slot  = SLOT_W'(q_head.slot);
	assign scan_slot = order_q[idx_q[SLOT_W-1:0]];
	assign scan_done = (idx_q == total_q);
	assign commit    = (state_q == aps_pkg::ST_SCAN) && scan_done;
	assign rej       = q_head.slot_ok && ready_q[cmd_slot];
	assign do_ready  = q_pop && q_head.op == aps_pkg::ACT_READY && q_head.slot_ok
		&& !ready_q[cmd_slot] && (32'(total_q) < MAX_TASKS);
	assign do_set    = q_pop && q_head.op == aps_pkg::ACT_SETPRIO && q_head.slot_ok;

	// Sequencer: one action at a time, pick scans one order entry per cycle
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			aps_pkg::ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_head.op == aps_pkg::ACT_PICK && total_q != '0) begin
						state_d = aps_pkg::ST_SCAN;
					end
				end
			end
			aps_pkg::ST_SCAN: begin
				if (scan_done) state_d = aps_pkg::ST_IDLE;
			end
			default: state_d = aps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan registers: running minimum, strict less keeps the earliest on ties
	always_ff @(posedge clk) begin
		if (q_pop) begin
			idx_q       <= CNT_W'(1);
			best_idx_q  <= '0;
			best_slot_q <= order_q[0];
			best_prio_q <= dyn_q[order_q[0]];
		end else if (state_q == aps_pkg::ST_SCAN && !scan_done) begin
			idx_q <= idx_q + CNT_W'(1);
			if (dyn_q[scan_slot] < best_prio_q) begin
				best_idx_q  <= idx_q;
				best_slot_q <= scan_slot;
				best_prio_q <= dyn_q[scan_slot];
			end
		end
	end

	// Ready order: append on make ready, close the gap on pick
	always_ff @(posedge clk) begin
		if (do_ready) begin
			order_q[total_q[SLOT_W-1:0]] <= cmd_slot;
		end else if (commit) begin
			for (int i = 0; i < MAX_TASKS - 1; i++) begin
				if (CNT_W'(i) >= best_idx_q) order_q[i] <= order_q[i + 1];
			end
		end
	end

	// Task tables, ready set and running task
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_TASKS; s++) begin
				static_q[s] <= '0;
				dyn_q[s]    <= '0;
			end
			ready_q     <= '0;
			total_q     <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
			budget_q    <= '0;
		end else begin
			if (do_ready) begin
				ready_q[cmd_slot] <= 1'b1;
				total_q           <= total_q + CNT_W'(1);
				if (q_head.new_task) begin
					static_q[cmd_slot] <= '0;
					dyn_q[cmd_slot]    <= '0;
				end
			end
			if (do_set) begin
				static_q[cmd_slot] <= q_head.prio;
				dyn_q[cmd_slot]    <= {{2{q_head.prio[5]}}, q_head.prio};
			end
			// Pick with an empty ready set
			if (q_pop && q_head.op == aps_pkg::ACT_PICK && total_q == '0) begin
				run_valid_q <= 1'b0;
			end
			if (q_pop && q_head.op == aps_pkg::ACT_TICK && run_valid_q) begin
				if (budget_q <= 8'd1) begin
					budget_q    <= '0;
					run_valid_q <= 1'b0;
				end else begin
					budget_q <= budget_q - 8'd1;
				end
			end
			if (commit) begin
				for (int s = 0; s < MAX_TASKS; s++) begin
					logic signed [8:0] aged;
					aged = $signed({dyn_q[s][7], dyn_q[s]}) - $signed({5'b0, aging_step});
					if (SLOT_W'(s) == best_slot_q) begin
						dyn_q[s] <= {{2{static_q[s][5]}}, static_q[s]};
					end else if (ready_q[s]) begin
						dyn_q[s] <= (aged < aps_pkg::DYN_FLOOR) ? 8'sh80 : aged[7:0];
					end
				end
				ready_q[best_slot_q] <= 1'b0;
				total_q     <= total_q - CNT_W'(1);
				run_slot_q  <= best_slot_q;
				run_valid_q <= 1'b1;
				budget_q    <= quantum;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((q_pop && !(q_head.op == aps_pkg::ACT_PICK && total_q != '0)) || commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_slot_q    <= 4'(best_slot_q);
			out_cvalid_q  <= 1'b1;
			out_preempt_q <= 1'b0;
			out_reject_q  <= 1'b0;
		end else if (q_pop) begin
			out_slot_q    <= '0;
			out_cvalid_q  <= 1'b0;
			out_preempt_q <= (q_head.op == aps_pkg::ACT_TICK) && run_valid_q
				&& (budget_q <= 8'd1);
			out_reject_q  <= (q_head.op == aps_pkg::ACT_READY) && rej;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.chosen_slot  = out_slot_q;
	assign rsp.chosen_valid = out_cvalid_q;
	assign rsp.preempt      = out_preempt_q;
	assign rsp.rejected     = out_reject_q;
	assign rsp.ready_count  = 5'(total_q);

	// Ready count always equals the number of ready slots
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(ready_q) == 32'(total_q))
		else $error("ready count out of step with ready set");

	// Scan never runs past the end of the ready order
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aps_pkg::ST_SCAN |-> idx_q <= total_q && total_q != '0)
		else $error("scan index beyond ready order");

	// A finished pick leaves its task running with a fresh budget
	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> run_valid_q && run_slot_q == $past(best_slot_q) && budget_q == $past(quantum))
		else $error("pick did not load running task");

	// No pop while a scan is in progress
	a_no_pop_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aps_pkg::ST_SCAN |-> !q_pop)
		else $error("queue popped during scan");

endmodule

// ----- rtl/aging_priority_scheduler.sv -----
// Top level of the aging priority scheduler: APB registers, front queue and back end.
// Items enter through a decoding front end with a two-entry queue, so the next item is
// taken while a result waits. The back end runs one item at a time: make ready, set
// priority, tick and a pick with nothing ready need no scan; a pick walks the ready
// order one entry per cycle to find the lowest dynamic priority. Registers:
// quantum_ticks at byte 0, aging_step at byte 4; write them only while the block is idle.
module aging_priority_scheduler #(
	parameter int MAX_TASKS = aps_pkg::MaxTasksDef
) (
	input  logic        clk,
	input  logic        arst_n,
	aps_req_if.sink     req,
	aps_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]     quantum_q;
	logic [3:0]     aging_q;
	aps_pkg::cmd_t  q_head;
	logic           q_valid;
	logic           q_pop;

	assign pready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= aps_pkg::QUANTUM_RST;
			aging_q   <= aps_pkg::AGING_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				aps_pkg::REG_QUANTUM: quantum_q <= pwdata[7:0];
				aps_pkg::REG_AGING:   aging_q   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Register read
	always_comb begin
		unique case (paddr[2])
			aps_pkg::REG_QUANTUM: prdata = {24'b0, quantum_q};
			aps_pkg::REG_AGING:   prdata = {28'b0, aging_q};
			default:              prdata = '0;
		endcase
	end

	aps_front #(.MAX_TASKS(MAX_TASKS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	aps_back #(.MAX_TASKS(MAX_TASKS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_head     (q_head),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.quantum    (quantum_q),
		.aging_step (aging_q),
		.rsp        (rsp)
	);

endmodule
